### design/extremum_half_wave_detector_top_macros.svh
// assertion helpers for the half-wave detector
`ifndef EXTREMUM_HALF_WAVE_DETECTOR_TOP_MACROS_SVH
`define EXTREMUM_HALF_WAVE_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define EHWD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ehwd assertion failed");

// next-cycle implication, checked out of reset
`define EHWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ehwd assertion failed");

`endif

### design/ehwd_pkg.sv
package ehwd_pkg;

    localparam int SAMPLE_W = 8;
    localparam int LEN_W    = 8;

    localparam logic [SAMPLE_W-1:0] ZERO_LEVEL       = 8'd128;
    localparam logic [LEN_W-1:0]    SCAN_LIMIT_RESET = 8'd236;

    typedef struct packed {
        logic [LEN_W-1:0] half_wave_length;
        logic             was_peak;
    } result_t;

    typedef struct packed {
        logic    valid;
        logic    fire;
        result_t data;
    } track_status_t;

endpackage

### design/extremum_half_wave_detector_top.sv
// extremum half-wave detector
// s_ channel: one unsigned 8-bit audio sample per word, 128 is the zero level.
// m_ channel: one word per detected peak or trough, carrying the half-wave
//   length (window position + 1) and whether the extremum was a peak.
// cfg channel: writes scan_limit, the number of window positions scanned
//   before the length count restarts without a result; cfg_ready is always high.
// the first WIN_LEN - 1 samples only fill the window and never give a result.
// a result is registered twice: its sample enters the window register, and the
//   evaluated window's result enters the output register once that slot is free.
// throughput: one sample per cycle while s_ready is high; the window register
//   feeds three group means and the compare logic combinationally, straight into the output register.
// stall: a result waiting on m_ready holds the output register; one more
//   evaluated window is held in the window stage, and s_ready drops only
//   when that window is also a hit.
// reset (aresetn low, synchronous): clears window, fill count, pending flag and position,
//   clears m_valid, sets the search to a trough first and scan_limit to 236.
module extremum_half_wave_detector_top #(
    parameter int AVG_LEN       = 6,
    parameter int GROUP_SPACING = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ehwd_pkg::SAMPLE_W-1:0]     s_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ehwd_pkg::LEN_W-1:0]        m_half_wave_length,
    output logic                              m_was_peak,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ehwd_pkg::LEN_W-1:0]        cfg_data
);

    `include "extremum_half_wave_detector_top_macros.svh"

    localparam int WIN_LEN = 2 * GROUP_SPACING + AVG_LEN;
    localparam int MEAN_W  = $clog2(128 * AVG_LEN + 1) + 1;

    logic [WIN_LEN-1:0][ehwd_pkg::SAMPLE_W-1:0] window;
    logic                                        pending;
    logic                                        s_accept;
    logic signed [MEAN_W-1:0]                    v1;
    logic signed [MEAN_W-1:0]                    v2;
    logic signed [MEAN_W-1:0]                    v3;
    logic [ehwd_pkg::LEN_W-1:0]                  scan_limit_reg;
    ehwd_pkg::track_status_t                     status;

    assign s_ready  = !pending || status.fire;
    assign s_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_limit_reg <= ehwd_pkg::SCAN_LIMIT_RESET;
        end else if (cfg_valid) begin
            scan_limit_reg <= cfg_data;
        end
    end

    ehwd_window #(
        .WIN_LEN (WIN_LEN)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .sample  (s_sample),
        .consume (status.fire),
        .window  (window),
        .pending (pending)
    );

    ehwd_mean #(
        .WIN_LEN (WIN_LEN),
        .AVG_LEN (AVG_LEN),
        .START   (0),
        .MEAN_W  (MEAN_W)
    ) u_mean1 (
        .window (window),
        .mean   (v1)
    );

    ehwd_mean #(
        .WIN_LEN (WIN_LEN),
        .AVG_LEN (AVG_LEN),
        .START   (GROUP_SPACING),
        .MEAN_W  (MEAN_W)
    ) u_mean2 (
        .window (window),
        .mean   (v2)
    );

    ehwd_mean #(
        .WIN_LEN (WIN_LEN),
        .AVG_LEN (AVG_LEN),
        .START   (2 * GROUP_SPACING),
        .MEAN_W  (MEAN_W)
    ) u_mean3 (
        .window (window),
        .mean   (v3)
    );

    ehwd_tracker #(
        .MEAN_W (MEAN_W)
    ) u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pending    (pending),
        .v1         (v1),
        .v2         (v2),
        .v3         (v3),
        .scan_limit (scan_limit_reg),
        .m_ready    (m_ready),
        .status     (status)
    );

    assign m_valid            = status.valid;
    assign m_half_wave_length = status.data.half_wave_length;
    assign m_was_peak         = status.data.was_peak;

    // length counts from one and never wraps to zero
    `EHWD_ASSERT_NOW(a_len_nonzero, m_valid, m_half_wave_length != '0)
    // the window stage stalls only behind a held result
    `EHWD_ASSERT_NOW(a_stall_cause, pending && !status.fire, m_valid && !m_ready)
    // a new result always comes from an evaluated window
    `EHWD_ASSERT_NEXT(a_result_source, !pending, !$rose(m_valid))

endmodule

### design/ehwd_window.sv
module ehwd_window #(
    parameter int WIN_LEN = 14
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         accept,
    input  logic [ehwd_pkg::SAMPLE_W-1:0]                sample,
    input  logic                                         consume,
    output logic [WIN_LEN-1:0][ehwd_pkg::SAMPLE_W-1:0]   window,
    output logic                                         pending
);

    localparam int FILL_W = $clog2(WIN_LEN + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_LEN);

    logic [WIN_LEN-1:0][ehwd_pkg::SAMPLE_W-1:0] window_reg;
    logic [WIN_LEN-1:0][ehwd_pkg::SAMPLE_W-1:0] window_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              pending_reg;
    logic              pending_next;

    // index 0 is the oldest sample
    always_comb begin
        for (int k = 0; k < WIN_LEN - 1; k++) begin
            window_next[k] = window_reg[k+1];
        end
        window_next[WIN_LEN-1] = sample;
    end

    always_comb begin
        fill_next = (fill_reg == FILL_FULL) ? FILL_FULL : fill_reg + FILL_W'(1);
        pending_next = pending_reg;
        if (accept) begin
            pending_next = (fill_next == FILL_FULL);
        end else if (consume) begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            fill_reg    <= '0;
            pending_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            if (accept) begin
                window_reg <= window_next;
                fill_reg   <= fill_next;
            end
        end
    end

    assign window  = window_reg;
    assign pending = pending_reg;

endmodule

### design/ehwd_mean.sv
module ehwd_mean #(
    parameter int WIN_LEN = 14,
    parameter int AVG_LEN = 6,
    parameter int START   = 0,
    parameter int MEAN_W  = 11
) (
    input  logic [WIN_LEN-1:0][ehwd_pkg::SAMPLE_W-1:0] window,
    output logic signed [MEAN_W-1:0]                   mean
);

    // magnitude of a sum fits in ABS_W bits, the signed sum in MEAN_W
    localparam int ABS_W  = MEAN_W - 1;
    localparam int SHIFT  = ABS_W + $clog2(AVG_LEN);
    localparam longint RECIP_VAL = ((longint'(1) << SHIFT) + AVG_LEN - 1) / AVG_LEN;
    localparam logic [SHIFT-1:0] RECIP = SHIFT'(RECIP_VAL);
    localparam int PROD_W = ABS_W + SHIFT;

    logic signed [MEAN_W-1:0] sum_v;
    logic                     neg;
    logic [MEAN_W-1:0]        mag_full;
    logic [ABS_W-1:0]         mag;
    logic [PROD_W-1:0]        prod;
    logic [ABS_W-1:0]         quot;
    logic [MEAN_W-1:0]        quot_ext;

    always_comb begin
        sum_v = '0;
        for (int k = 0; k < AVG_LEN; k++) begin
            sum_v = sum_v + $signed(MEAN_W'(window[START+k]))
                          - $signed(MEAN_W'(ehwd_pkg::ZERO_LEVEL));
        end
    end

    // divide magnitude by the group length via reciprocal, truncating toward zero
    assign neg      = sum_v[MEAN_W-1];
    assign mag_full = neg ? MEAN_W'(-sum_v) : MEAN_W'(sum_v);
    assign mag      = mag_full[ABS_W-1:0];
    assign prod     = PROD_W'(mag) * PROD_W'(RECIP);
    assign quot     = prod[PROD_W-1:SHIFT];
    assign quot_ext = MEAN_W'(quot);
    assign mean     = neg ? -$signed(quot_ext) : $signed(quot_ext);

endmodule

### design/ehwd_tracker.sv
module ehwd_tracker #(
    parameter int MEAN_W = 11
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              pending,
    input  logic signed [MEAN_W-1:0]          v1,
    input  logic signed [MEAN_W-1:0]          v2,
    input  logic signed [MEAN_W-1:0]          v3,
    input  logic [ehwd_pkg::LEN_W-1:0]        scan_limit,
    input  logic                              m_ready,
    output ehwd_pkg::track_status_t           status
);

    localparam int LEN_W = ehwd_pkg::LEN_W;

    logic                    hunting_peak_reg;
    logic                    hunting_peak_next;
    logic [LEN_W-1:0]        position_reg;
    logic [LEN_W-1:0]        position_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    ehwd_pkg::result_t       result_reg;
    ehwd_pkg::result_t       result_next;
    logic                    hit;
    logic                    out_free;
    logic                    fire;
    logic [LEN_W:0]          pos_inc;

    assign hit = hunting_peak_reg ? ((v1 <= v2) && (v3 < v2))
                                  : ((v1 >= v2) && (v3 > v2));

    // a miss never needs the output slot
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = pending && (!hit || out_free);
    assign pos_inc  = (LEN_W+1)'(position_reg) + (LEN_W+1)'(1);

    always_comb begin
        hunting_peak_next = hunting_peak_reg;
        position_next     = position_reg;
        result_next       = result_reg;
        m_valid_next      = m_ready ? 1'b0 : m_valid_reg;
        if (fire) begin
            if (hit) begin
                result_next.half_wave_length = pos_inc[LEN_W-1:0];
                result_next.was_peak         = hunting_peak_reg;
                m_valid_next                 = 1'b1;
                hunting_peak_next            = !hunting_peak_reg;
                position_next                = '0;
            end else if (pos_inc >= (LEN_W+1)'(scan_limit) || pos_inc[LEN_W]) begin
                position_next = '0;
            end else begin
                position_next = pos_inc[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hunting_peak_reg <= 1'b0;
            position_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            hunting_peak_reg <= hunting_peak_next;
            position_reg     <= position_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign status.valid = m_valid_reg;
    assign status.fire  = fire;
    assign status.data  = result_reg;

endmodule
